### rtl/core/fdl_pkg.sv
// Shared types and constants of the fractional delay line.
`default_nettype none

package fdl_pkg;

    // Ring geometry. The ring depth is a power of two so that pointer
    // arithmetic wraps by truncation.
    localparam int RING_DEPTH = 1024;
    localparam int PTR_W      = $clog2(RING_DEPTH);
    localparam int FILL_W     = PTR_W + 1;

    // Field widths.
    localparam int SAMPLE_W   = 16;
    localparam int BULK_W     = 10;
    localparam int FRAC_W     = 16;
    localparam int LOOK_W     = 11;

    // Datapath widths: difference of two samples, its product with the
    // fraction, the shifted product and the final sum before saturation.
    localparam int DIFF_W     = SAMPLE_W + 1;
    localparam int PROD_W     = DIFF_W + FRAC_W;
    localparam int SHIFT_W    = PROD_W - FRAC_W;
    localparam int SUM_W      = SHIFT_W + 1;

    // Largest bulk delay the ring supports.
    localparam logic [BULK_W-1:0] BULK_MAX = BULK_W'(RING_DEPTH - 2);

    // Configuration port.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_BULK_DELAY = 1'b0;
    localparam logic REG_FRAC_DELAY = 1'b1;

    typedef enum logic
    {
        OP_WRITE = 1'b0,
        OP_READ  = 1'b1
    } op_t;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [PTR_W-1:0]           ptr_t;

endpackage

`default_nettype wire

### rtl/core/ref_fractional_delay_line_core.sv
// Top level of the fractional delay line: sample ring, read pipeline and register port.
`default_nettype none

// Channel     Direction  Handshake             Payload
// input       in         in_valid / in_stall   opcode, sensed_sample, sensed_valid,
//                                              mixer_sample, mixer_valid, lookback
// output      out        out_valid / out_stall aligned_sample
// config      in         psel/penable/pwrite   paddr, pwdata, prdata, pready
//
// One input transfer is taken per clock cycle while in_stall is low. A write transfer stores
// its sample into the ring at the accepting edge and produces no result. A read transfer
// registers both ring taps at its accepting edge, then the product, then the saturated sum in
// the output register, which drives the output. Reads follow each other back to back, since
// the ring has two read ports for the two neighboring taps.
// Reset clears the write pointer, the registers and the pipeline valid bits at once; the
// ring itself is never swept, a fill count marks which entries have been written.
// A stall on the output holds the result register; the pipeline keeps taking transfers
// until all three stages hold a result, and only then stalls the input.

module ref_fractional_delay_line_core
    import fdl_pkg::*;
(
    input  wire                    clk,
    input  wire                    rst_n,

    input  wire                    in_valid,
    output logic                   in_stall,
    input  wire                    opcode,
    input  wire  [SAMPLE_W-1:0]    sensed_sample,
    input  wire                    sensed_valid,
    input  wire  [SAMPLE_W-1:0]    mixer_sample,
    input  wire                    mixer_valid,
    input  wire  [LOOK_W-1:0]      lookback,

    output logic                   out_valid,
    input  wire                    out_stall,
    output logic [SAMPLE_W-1:0]    aligned_sample,

    input  wire                    psel,
    input  wire                    penable,
    input  wire                    pwrite,
    input  wire  [APB_ADDR_W-1:0]  paddr,
    input  wire  [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready
);

    // ------------------------------------------------------------------
    // Configuration registers. Registers are word aligned, so only the
    // word-select address bit decodes; the bulk delay saturates on write.
    // ------------------------------------------------------------------
    logic [BULK_W-1:0] bulk_delay_reg;
    logic [FRAC_W-1:0] frac_delay_reg;
    logic              cfg_wr;
    logic [BULK_W-1:0] bulk_wdata;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        bulk_wdata = pwdata[BULK_W-1:0];
        if (bulk_wdata > BULK_MAX)
        begin
            bulk_wdata = BULK_MAX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bulk_delay_reg <= '0;
            frac_delay_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_BULK_DELAY: bulk_delay_reg <= bulk_wdata;
                REG_FRAC_DELAY: frac_delay_reg <= pwdata[FRAC_W-1:0];
                default:        bulk_delay_reg <= bulk_delay_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_BULK_DELAY: prdata = {{(APB_DATA_W-BULK_W){1'b0}}, bulk_delay_reg};
            REG_FRAC_DELAY: prdata = {{(APB_DATA_W-FRAC_W){1'b0}}, frac_delay_reg};
            default:        prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline flow control. Each stage loads when it is empty or when the
    // stage after it moves on, so bubbles collapse under an output stall.
    // ------------------------------------------------------------------
    logic v1_reg;
    logic v2_reg;
    logic out_valid_reg;
    logic en_out;
    logic en2;
    logic en1;
    logic in_acc;
    logic wr_acc;
    logic rd_acc;

    assign en_out   = !out_valid_reg || !out_stall;
    assign en2      = !v2_reg || en_out;
    assign en1      = !v1_reg || en2;
    assign in_stall = !en1;
    assign in_acc   = in_valid && !in_stall;
    assign wr_acc   = in_acc && (op_t'(opcode) == OP_WRITE);
    assign rd_acc   = in_acc && (op_t'(opcode) == OP_READ);

    // ------------------------------------------------------------------
    // Write pointer and fill count. Writes land in order from entry zero,
    // so an entry holds written data exactly when its index is below the
    // fill count; all other entries read as the cleared value of zero.
    // ------------------------------------------------------------------
    ptr_t              wp_reg;
    ptr_t              wp_next;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;

    always_comb
    begin
        wp_next   = wp_reg;
        fill_next = fill_reg;
        if (wr_acc)
        begin
            wp_next = wp_reg + 1'b1;
            if (fill_reg != FILL_W'(RING_DEPTH))
            begin
                fill_next = fill_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= '0;
            fill_reg <= '0;
        end
        else
        begin
            wp_reg   <= wp_next;
            fill_reg <= fill_next;
        end
    end

    // ------------------------------------------------------------------
    // Sample ring: one write port, two read ports with registered data.
    // A read samples the ring at its own accepting edge, and only one
    // transfer is accepted per edge, so a read never races a write to the
    // same entry and no forwarding is needed.
    // ------------------------------------------------------------------
    sample_t ring_mem [RING_DEPTH];
    sample_t wr_sample;
    ptr_t    pos0;
    ptr_t    pos1;
    sample_t rd0_reg;
    sample_t rd1_reg;
    logic    ok0_reg;
    logic    ok1_reg;

    always_comb
    begin
        priority if (sensed_valid)
        begin
            wr_sample = sensed_sample;
        end
        else if (mixer_valid)
        begin
            wr_sample = mixer_sample;
        end
        else
        begin
            wr_sample = '0;
        end
    end

    // The read position wraps modulo the ring depth by truncation.
    assign pos0 = PTR_W'(wp_reg - PTR_W'(bulk_delay_reg) - PTR_W'(lookback));
    assign pos1 = pos0 + 1'b1;

    always_ff @(posedge clk)
    begin
        if (wr_acc)
        begin
            ring_mem[wp_reg] <= wr_sample;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_acc)
        begin
            rd0_reg <= ring_mem[pos0];
            rd1_reg <= ring_mem[pos1];
            ok0_reg <= fill_reg > {1'b0, pos0};
            ok1_reg <= fill_reg > {1'b0, pos1};
        end
    end

    // ------------------------------------------------------------------
    // Stage one: difference of the two taps times the fraction.
    // ------------------------------------------------------------------
    sample_t                   s0;
    sample_t                   s1;
    logic signed [DIFF_W-1:0]  diff;
    logic signed [PROD_W:0]    prod_full;
    logic signed [PROD_W-1:0]  prod_reg;
    sample_t                   s0_reg;

    assign s0        = ok0_reg ? rd0_reg : '0;
    assign s1        = ok1_reg ? rd1_reg : '0;
    assign diff      = DIFF_W'(s1) - DIFF_W'(s0);
    assign prod_full = $signed({1'b0, frac_delay_reg}) * diff;

    always_ff @(posedge clk)
    begin
        if (en2 && v1_reg)
        begin
            prod_reg <= prod_full[PROD_W-1:0];
            s0_reg   <= s0;
        end
    end

    // ------------------------------------------------------------------
    // Stage two: floor shift of the product, add and saturate.
    // ------------------------------------------------------------------
    logic signed [SHIFT_W-1:0] step;
    logic signed [SUM_W-1:0]   sum;
    sample_t                   sat;
    sample_t                   out_reg;

    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((1 << (SAMPLE_W - 1)) - 1);
    localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

    assign step = prod_reg[PROD_W-1:FRAC_W];
    assign sum  = SUM_W'(s0_reg) + SUM_W'(step);

    always_comb
    begin
        priority if (sum > SAT_HI)
        begin
            sat = SAMPLE_W'(SAT_HI);
        end
        else if (sum < SAT_LO)
        begin
            sat = SAMPLE_W'(SAT_LO);
        end
        else
        begin
            sat = sum[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_out && v2_reg)
        begin
            out_reg <= sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= rd_acc;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en_out)
            begin
                out_valid_reg <= v2_reg;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign aligned_sample = out_reg;

`ifndef SYNTHESIS
    // The fill count never runs past the ring depth.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(RING_DEPTH))
        else $error("fill count exceeds ring depth");

    // A stored bulk delay always leaves room for both interpolation taps.
    a_bulk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        bulk_delay_reg <= BULK_MAX)
        else $error("bulk delay above its clamp");

    // Each accepted write advances the pointer by exactly one entry.
    a_wp_step: assert property (@(posedge clk) disable iff (!rst_n)
        wr_acc |=> wp_reg == $past(wp_reg) + 1'b1)
        else $error("write pointer did not advance");

    // An accepted read always occupies the first pipeline stage next cycle.
    a_rd_enter: assert property (@(posedge clk) disable iff (!rst_n)
        rd_acc |=> v1_reg)
        else $error("read transfer lost at pipeline entry");
`endif

endmodule

`default_nettype wire

### tb/sv/delay_line_check_pkg.sv
// Scoreboard for the fractional delay line: a ring predictor and the queue of expected samples.
`timescale 1ns / 100ps

package delay_line_check_pkg;

    import fdl_pkg::*;

    // One input transfer as the driver presents it.
    typedef struct packed
    {
        op_t               op;
        sample_t           sensed;
        logic              sensed_ok;
        sample_t           mixer;
        logic              mixer_ok;
        logic [LOOK_W-1:0] look;
    } far_end_item_t;

    class aligned_sample_board;

        sample_t           ring [RING_DEPTH];
        ptr_t              wr_ptr;
        logic [BULK_W-1:0] bulk;
        logic [FRAC_W-1:0] frac;
        sample_t           pending [$];
        int                errors;

        function new();
            foreach (ring[i])
            begin
                ring[i] = '0;
            end
            wr_ptr = '0;
            bulk   = '0;
            frac   = '0;
            errors = 0;
        endfunction

        // Mirrors a register write; bulk delay saturates at the deepest usable tap.
        function void set_register(logic [APB_ADDR_W-1:0] addr, logic [APB_DATA_W-1:0] value);
            logic [BULK_W-1:0] raw;
            raw = value[BULK_W-1:0];
            if (addr[2] == REG_BULK_DELAY)
            begin
                bulk = (raw > BULK_MAX) ? BULK_MAX : raw;
            end
            else
            begin
                frac = value[FRAC_W-1:0];
            end
        endfunction

        // Applies one accepted transfer; a read queues the interpolated sample it must return.
        function void note_transfer(far_end_item_t item);
            ptr_t   pos;
            longint s0;
            longint s1;
            longint step;
            longint sum;
            if (item.op == OP_WRITE)
            begin
                if (item.sensed_ok)
                begin
                    ring[wr_ptr] = item.sensed;
                end
                else if (item.mixer_ok)
                begin
                    ring[wr_ptr] = item.mixer;
                end
                else
                begin
                    ring[wr_ptr] = '0;
                end
                wr_ptr = wr_ptr + 1'b1;
            end
            else
            begin
                // Pointer arithmetic wraps at the ring depth, so any lookback is legal.
                pos  = wr_ptr - ptr_t'(bulk) - ptr_t'(item.look);
                s0   = ring[pos];
                s1   = ring[ptr_t'(pos + 1'b1)];
                step = (longint'(frac) * (s1 - s0)) >>> FRAC_W;
                sum  = s0 + step;
                if (sum > 32767)
                begin
                    sum = 32767;
                end
                else if (sum < -32768)
                begin
                    sum = -32768;
                end
                pending.push_back(sample_t'(sum));
            end
        endfunction

        function void check_aligned(logic [SAMPLE_W-1:0] got);
            sample_t want;
            if (pending.size() == 0)
            begin
                errors++;
                $display("%0t ns: aligned_sample expected none, got %0d", $time, $signed(got));
                return;
            end
            want = pending.pop_front();
            if (got !== want)
            begin
                errors++;
                $display("%0t ns: aligned_sample expected %0d, got %0d",
                         $time, want, $signed(got));
            end
        endfunction

    endclass

endpackage

### tb/sv/testbench.sv
// Top level of the fractional delay line testbench: clock, reset, drivers, monitor and watchdog.
`timescale 1ns / 100ps

module testbench;

    import fdl_pkg::*;
    import delay_line_check_pkg::*;

    // Cycles to let pass after the last expected sample, covering the three-stage read pipeline.
    localparam int SETTLE_CYCLES = 8;
    // Cycles with no transfer on any port before the run is declared hung.
    localparam int QUIET_LIMIT   = 2000;
    // Length of the forced output hold-off that fills the pipeline.
    localparam int HOLD_OFF_LEN  = 120;
    localparam int SEGMENT_ITEMS = 148;

    logic                  clk;
    logic                  rst_n          = 1'b0;

    logic                  in_valid       = 1'b0;
    logic                  in_stall;
    logic                  opcode         = 1'b0;
    logic [SAMPLE_W-1:0]   sensed_sample  = '0;
    logic                  sensed_valid   = 1'b0;
    logic [SAMPLE_W-1:0]   mixer_sample   = '0;
    logic                  mixer_valid    = 1'b0;
    logic [LOOK_W-1:0]     lookback       = '0;

    logic                  out_valid;
    logic                  out_stall      = 1'b0;
    logic [SAMPLE_W-1:0]   aligned_sample;

    logic                  psel           = 1'b0;
    logic                  penable        = 1'b0;
    logic                  pwrite         = 1'b0;
    logic [APB_ADDR_W-1:0] paddr          = '0;
    logic [APB_DATA_W-1:0] pwdata         = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Percentages of cycles in which the sender idles and the receiver stalls.
    int idle_pct  = 0;
    int stall_pct = 0;

    // The main process raises this flag; the receiver process counts the hold-off itself.
    bit hold_off_go   = 1'b0;
    int hold_off_left = 0;
    int quiet_cycles  = 0;

    aligned_sample_board board = new();

    ref_fractional_delay_line_core i_dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Receiver: random stalls, or a long unbroken stall when a hold-off is requested.
    always @(posedge clk)
    begin
        if (hold_off_go)
        begin
            hold_off_go   = 1'b0;
            hold_off_left = HOLD_OFF_LEN;
        end
        if (hold_off_left > 0)
        begin
            hold_off_left = hold_off_left - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Output monitor. Sampling at the edge sees the values that the edge itself acts on.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            board.check_aligned(aligned_sample);
        end
    end

    // Watchdog: any transfer on the input, the output or the register port counts as progress.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles = quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Offers one item and holds it until the block takes it. The valid stays high into the
    // next call unless an idle gap is drawn, so valid is never lowered and raised in one step.
    task automatic send_transfer(far_end_item_t item);
        in_valid      <= 1'b1;
        opcode        <= item.op;
        sensed_sample <= item.sensed;
        sensed_valid  <= item.sensed_ok;
        mixer_sample  <= item.mixer;
        mixer_valid   <= item.mixer_ok;
        lookback      <= item.look;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        board.note_transfer(item);
        if (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    // Stops offering and waits until every queued sample has come out. Writes cause no
    // result, so the pipeline is given a few more cycles to go idle afterwards.
    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Setup cycle, then access cycle; the register takes the data at the edge ending the access.
    task automatic write_register(logic reg_sel, logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board.set_register({reg_sel, 2'b00}, value);
        @(posedge clk);
    endtask

    task automatic configure(logic [APB_DATA_W-1:0] bulk_word, logic [APB_DATA_W-1:0] frac_word);
        write_register(REG_BULK_DELAY, bulk_word);
        write_register(REG_FRAC_DELAY, frac_word);
    endtask

    function automatic far_end_item_t make_item(op_t op, int sensed, logic sensed_ok,
                                                int mixer, logic mixer_ok, int look);
        far_end_item_t item;
        item.op        = op;
        item.sensed    = sample_t'(sensed);
        item.sensed_ok = sensed_ok;
        item.mixer     = sample_t'(mixer);
        item.mixer_ok  = mixer_ok;
        item.look      = LOOK_W'(look);
        return item;
    endfunction

    // Full-scale values show up often enough to exercise the interpolation extremes.
    function automatic sample_t pick_sample();
        if ($urandom_range(7) == 0)
        begin
            case ($urandom_range(3))
                0:       return sample_t'(32767);
                1:       return sample_t'(-32768);
                2:       return sample_t'(0);
                default: return sample_t'(-1);
            endcase
        end
        return sample_t'($urandom);
    endfunction

    // Writes and reads in roughly equal share. Most reads look a short way back so they land
    // on written samples; some span the whole ring and a few use the full field, wrapping.
    function automatic far_end_item_t random_item();
        far_end_item_t item;
        item.op        = ($urandom_range(99) < 52) ? OP_WRITE : OP_READ;
        item.sensed    = pick_sample();
        item.mixer     = pick_sample();
        item.sensed_ok = 1'($urandom_range(1));
        item.mixer_ok  = 1'($urandom_range(1));
        case ($urandom_range(9))
            7, 8:    item.look = LOOK_W'($urandom_range(1, RING_DEPTH));
            9:       item.look = LOOK_W'($urandom_range(0, (1 << LOOK_W) - 1));
            default: item.look = LOOK_W'($urandom_range(1, 48));
        endcase
        return item;
    endfunction

    initial
    begin
        int seg_id;
        logic [APB_DATA_W-1:0] bulk_word;
        logic [APB_DATA_W-1:0] frac_word;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. A read before any write returns the cleared ring.
        configure(0, 0);
        send_transfer(make_item(OP_READ, 0, 1'b0, 0, 1'b0, 1));
        // Source selection: sensed wins over mixer, mixer alone, and neither stores zero.
        send_transfer(make_item(OP_WRITE, 32767, 1'b1, 16'h1234, 1'b1, 0));
        send_transfer(make_item(OP_WRITE, -32768, 1'b1, 0, 1'b0, 2047));
        send_transfer(make_item(OP_WRITE, 16'h5555, 1'b0, 32767, 1'b1, 0));
        send_transfer(make_item(OP_WRITE, 16'hAAAA, 1'b0, -32768, 1'b1, 0));
        send_transfer(make_item(OP_WRITE, -1, 1'b0, -1, 1'b0, 0));
        send_transfer(make_item(OP_WRITE, -1, 1'b1, 32767, 1'b1, 0));
        // Zero fraction returns the tap itself; a lookback of zero or past the ring wraps.
        send_transfer(make_item(OP_READ, 0, 1'b0, 0, 1'b0, 6));
        send_transfer(make_item(OP_READ, 0, 1'b0, 0, 1'b0, 3));
        send_transfer(make_item(OP_READ, 0, 1'b0, 0, 1'b0, 0));
        send_transfer(make_item(OP_READ, 0, 1'b0, 0, 1'b0, 2047));
        drain();
        // Largest fraction across full-scale neighbors in both directions.
        configure(2, 16'hFFFF);
        send_transfer(make_item(OP_READ, -1, 1'b1, -1, 1'b1, 4));
        send_transfer(make_item(OP_READ, 0, 1'b0, 0, 1'b0, 3));
        send_transfer(make_item(OP_READ, 0, 1'b0, 0, 1'b0, 2));
        send_transfer(make_item(OP_READ, 0, 1'b0, 0, 1'b0, 1));
        drain();
        // An oversized bulk delay saturates at the deepest tap.
        configure(1023, 16'h8000);
        send_transfer(make_item(OP_READ, 0, 1'b0, 0, 1'b0, 1024));
        send_transfer(make_item(OP_READ, 0, 1'b0, 0, 1'b0, 1025));
        send_transfer(make_item(OP_READ, 0, 1'b0, 0, 1'b0, 1));
        send_transfer(make_item(OP_WRITE, 100, 1'b1, 0, 1'b0, 0));
        send_transfer(make_item(OP_READ, 0, 1'b0, 0, 1'b0, 2047));
        drain();

        // Random part in three idling phases, each with three register settings. Every change
        // of setting waits until the block has returned everything, which is the sender pause.
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    idle_pct  = 14;
                    stall_pct = 72;
                end
                1:
                begin
                    idle_pct  = 72;
                    stall_pct = 14;
                end
                default:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
            endcase
            for (int seg = 0; seg < 3; seg++)
            begin
                seg_id = phase * 3 + seg;
                case (seg_id)
                    0:       bulk_word = 0;
                    1:       bulk_word = BULK_MAX;
                    2:       bulk_word = 32'd1023;
                    3:       bulk_word = $urandom;
                    default: bulk_word = $urandom_range(0, 20);
                endcase
                case (seg_id)
                    0:       frac_word = 32'h0000_FFFF;
                    1:       frac_word = 0;
                    2:       frac_word = $urandom;
                    3:       frac_word = 1;
                    default: frac_word = $urandom_range(0, 65535);
                endcase
                drain();
                configure(bulk_word, frac_word);
                // With no idling on either side, a long output hold-off backs the pipeline
                // up until the input stalls while the sender keeps offering.
                if (phase == 2 && seg == 1)
                begin
                    hold_off_go = 1'b1;
                end
                repeat (SEGMENT_ITEMS) send_transfer(random_item());
            end
        end

        drain();
        if (board.errors == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/core/fdl_pkg.sv
rtl/core/ref_fractional_delay_line_core.sv
tb/sv/delay_line_check_pkg.sv
tb/sv/testbench.sv
